[sv/csafe_frame_receiver_unit_macros.svh]
// Assertion macros shared by the receiver's RTL files.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef CSAFE_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CSAFE_FRAME_RECEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSAFE_FR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSAFE_FR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/csafe_fr_pkg.sv]
package csafe_fr_pkg;

  localparam logic [7:0] BYTE_START = 8'hF1;
  localparam logic [7:0] BYTE_END   = 8'hF2;
  localparam logic [7:0] BYTE_ESC   = 8'hF3;
  localparam logic [7:0] BYTE_BASE  = 8'hF0;
  localparam logic [7:0] CMD_SPEED  = 8'h53;
  localparam logic [7:0] CMD_GRADE  = 8'h58;
  localparam logic [7:0] CMD_STATUS = 8'h80;

  // Decoded payload bytes besides the declared data: command, length, checksum.
  localparam int unsigned FRAME_OVERHEAD = 3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_STUFF = 2'd2
  } rx_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SUM   = 2'd1,
    ST_SHORT     = 2'd2,
    ST_LEN_ERROR = 2'd3
  } frame_status_t;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_SPEED   = 2'd1,
    KIND_GRADE   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } reply_kind_t;

  typedef struct packed {
    frame_status_t frame_status;
    logic [7:0]    command_code;
    logic [7:0]    data_length;
    reply_kind_t   reply_kind;
    logic [15:0]   raw_value;
    logic          value_valid;
  } result_t;

endpackage

[sv/csafe_fr_ifs.sv]
interface csafe_fr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface csafe_fr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  command_code;
  logic [7:0]  data_length;
  logic [1:0]  reply_kind;
  logic [15:0] raw_value;
  logic        value_valid;

  modport source (
    output valid, output frame_status, output command_code, output data_length,
    output reply_kind, output raw_value, output value_valid, input ready
  );
  modport sink (
    input valid, input frame_status, input command_code, input data_length,
    input reply_kind, input raw_value, input value_valid, output ready
  );
endinterface

[sv/csafe_fr_decode.sv]
module csafe_fr_decode #(
  parameter int unsigned COUNT_WIDTH = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            byte_i,
  input  logic                  fire_i,
  output logic                  has_result_o,
  output csafe_fr_pkg::result_t result_o
);
  import csafe_fr_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_OVHD = COUNT_WIDTH'(FRAME_OVERHEAD);

  rx_mode_t               mode_r, mode_nxt;
  logic [7:0]             xor_r, xor_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [7:0]             cmd_r, cmd_nxt;
  logic [7:0]             len_r, len_nxt;
  logic [7:0]             dlo_r, dlo_nxt;
  logic [7:0]             dhi_r, dhi_nxt;

  logic                   active;
  logic                   is_data;
  logic [7:0]             decoded;
  logic [COUNT_WIDTH-1:0] expected;
  frame_status_t          status;
  reply_kind_t            kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      xor_r   <= '0;
      count_r <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      dlo_r   <= '0;
      dhi_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      xor_r   <= xor_nxt;
      count_r <= count_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      dlo_r   <= dlo_nxt;
      dhi_r   <= dhi_nxt;
    end
  end

  assign active  = (mode_r == MODE_RECV) || (mode_r == MODE_STUFF);
  assign is_data = (byte_i != BYTE_START) && (byte_i != BYTE_END) && (byte_i != BYTE_ESC);
  // A stuffed byte of 0 to 3 stands for 0xF0 to 0xF3, the base code and the framing codes.
  assign decoded = ((mode_r == MODE_STUFF) && (byte_i <= 8'd3)) ? (BYTE_BASE | byte_i) : byte_i;

  always_comb begin
    mode_nxt  = mode_r;
    xor_nxt   = xor_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    dlo_nxt   = dlo_r;
    dhi_nxt   = dhi_r;
    if (fire_i) begin
      if (byte_i == BYTE_START) begin
        mode_nxt  = MODE_RECV;
        xor_nxt   = '0;
        count_nxt = '0;
        cmd_nxt   = '0;
        len_nxt   = '0;
        dlo_nxt   = '0;
        dhi_nxt   = '0;
      end else if (byte_i == BYTE_END) begin
        mode_nxt = MODE_IDLE;
      end else if (byte_i == BYTE_ESC) begin
        if (mode_r == MODE_RECV) begin
          mode_nxt = MODE_STUFF;
        end
      end else if (active) begin
        mode_nxt = MODE_RECV;
        xor_nxt  = xor_r ^ decoded;
        if (count_r == COUNT_WIDTH'(0)) begin
          cmd_nxt = decoded;
        end
        if (count_r == COUNT_WIDTH'(1)) begin
          len_nxt = decoded;
        end
        if (count_r == COUNT_WIDTH'(2)) begin
          dlo_nxt = decoded;
        end
        if (count_r == COUNT_WIDTH'(3)) begin
          dhi_nxt = decoded;
        end
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + COUNT_WIDTH'(1);
        end
      end
    end
  end

  assign expected = COUNT_WIDTH'(len_r) + COUNT_OVHD;

  always_comb begin
    priority if (count_r < COUNT_OVHD) begin
      status = ST_SHORT;
    end else if (xor_r != 8'd0) begin
      status = ST_BAD_SUM;
    end else if (count_r != expected) begin
      status = ST_LEN_ERROR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    unique case (cmd_r)
      CMD_STATUS: kind = KIND_STATUS;
      CMD_SPEED:  kind = KIND_SPEED;
      CMD_GRADE:  kind = KIND_GRADE;
      default:    kind = KIND_UNKNOWN;
    endcase
  end

  assign has_result_o          = (byte_i == BYTE_END) && active && !is_data;
  assign result_o.frame_status = status;
  assign result_o.command_code = cmd_r;
  assign result_o.data_length  = len_r;
  assign result_o.reply_kind   = kind;
  assign result_o.raw_value    = {dhi_r, dlo_r};
  assign result_o.value_valid  = (status == ST_OK) &&
                                 ((kind == KIND_SPEED) || (kind == KIND_GRADE)) &&
                                 (len_r >= 8'd3);
endmodule

[sv/csafe_fr_out_reg.sv]
module csafe_fr_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  csafe_fr_pkg::result_t  result_i,
  output logic                   slot_free_o,
  csafe_fr_result_if.source      out_ch
);
  import csafe_fr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign slot_free_o = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      data_r <= result_i;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.frame_status = data_r.frame_status;
  assign out_ch.command_code = data_r.command_code;
  assign out_ch.data_length  = data_r.data_length;
  assign out_ch.reply_kind   = data_r.reply_kind;
  assign out_ch.raw_value    = data_r.raw_value;
  assign out_ch.value_valid  = data_r.value_valid;
endmodule

[sv/csafe_frame_receiver_unit.sv]
// A frame's result is offered by the output register once its end byte, held in the input register, is used.
// Throughput: one byte per cycle except during the stall below; the receive state is updated in a single pass.
// A byte waits in the input register only while an end byte's result cannot
// be placed because the output register is full and not being taken.
// Reset (rst_n low, synchronous): idle, checksum, count and held bytes cleared,
// both registers empty.
`include "csafe_frame_receiver_unit_macros.svh"

module csafe_frame_receiver_unit #(
  parameter int unsigned COUNT_WIDTH = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  csafe_fr_byte_if.sink     in_ch,
  csafe_fr_result_if.source out_ch
);
  import csafe_fr_pkg::*;

  // Input register: one received byte waiting to be folded into the frame state.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  logic       consume;
  logic       has_result;
  logic       slot_free;
  logic       out_load;
  result_t    result;

  // The held byte is used up unless it ends a frame and the output slot is busy.
  assign consume     = in_valid_r && (!has_result || slot_free);
  assign out_load    = consume && has_result;
  assign in_ch.ready = !in_valid_r || consume;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      in_valid_nxt = 1'b1;
    end else if (consume) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // Frame state and result logic. State only moves when the held byte is used.
  csafe_fr_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_i       (in_byte_r),
    .fire_i       (consume),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // Output register decouples the result side from the byte side.
  csafe_fr_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (out_load),
    .result_i    (result),
    .slot_free_o (slot_free),
    .out_ch      (out_ch)
  );

  `CSAFE_FR_ASSERT_SAME(a_load_on_end, out_load, in_byte_r == BYTE_END, "result without end byte")
  `CSAFE_FR_ASSERT_NEXT(a_hold_stalled, in_valid_r && !consume, in_valid_r, "stalled byte lost")
  `CSAFE_FR_ASSERT_SAME(a_value_ok, out_ch.valid && out_ch.value_valid, out_ch.frame_status == ST_OK, "value valid on bad frame")
  `CSAFE_FR_ASSERT_SAME(a_value_kind, out_ch.valid && out_ch.value_valid, out_ch.reply_kind == KIND_SPEED || out_ch.reply_kind == KIND_GRADE, "value valid on wrong kind")

endmodule
